### rtl/core/imhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhpq_pkg: shared types and constants for the indexed min-heap queue
// Item formats, operation and status codes, datapath command/status structs.
// ----------------------------------------------------------------------------
package imhpq_pkg;

    localparam int HEAP_CAPACITY_DEF = 1024;
    localparam int VERTEX_COUNT_DEF  = 1024;
    localparam int KEY_BITS_DEF      = 32;

    localparam int VERTEX_W = 10;
    localparam int DIST_W   = 32;
    localparam int COUNT_W  = 11;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_EXTRACT  = 2'd1,
        OP_DECREASE = 2'd2,
        OP_QUERY    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_ABSENT  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]          operation;
        logic [VERTEX_W-1:0] vertex;
        logic [DIST_W-1:0]   distance;
    } t_in_item;

    typedef struct packed {
        logic [VERTEX_W-1:0] out_vertex;
        logic [DIST_W-1:0]   out_distance;
        logic                present;
        logic                heap_empty;
        logic [COUNT_W-1:0]  entry_count;
        logic [1:0]          status;
    } t_out_item;

    // datapath micro-operations issued by the controller
    typedef enum logic [3:0] {
        DC_NOP,        // idle
        DC_LATCH,      // capture input item
        DC_VS_RD,      // read slot map at input vertex
        DC_INS_START,  // insert: grow heap, cursor = size-1
        DC_DEC_START,  // decrease: cursor = slot of vertex
        DC_UP_RD,      // read parent entry
        DC_UP_MOVE,    // move parent down to cursor, cursor = parent
        DC_UP_PLACE,   // place held entry at cursor
        DC_EX_RD_ROOT, // read root
        DC_EX_TAKE,    // record root, clear its slot, shrink, read last
        DC_EX_PUT,     // hold = last entry, cursor = 0
        DC_DN_RD_L,    // read left child
        DC_DN_RD_R,    // read right child
        DC_DN_MOVE,    // move best child up, cursor = child
        DC_DN_PLACE    // place held entry at cursor
    } t_dcmd;

    typedef struct packed {
        logic       present;   // vertex in heap (after DC_VS_RD)
        logic       full;
        logic       empty;
        logic       vert_bad;
        logic       at_root;
        logic       up_go;     // held key < parent key
        logic       dn_has_l;
        logic       dn_has_r;
        logic       dn_go;     // a child beats the held key
    } t_dstat;

endpackage

### rtl/core/imhpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhpq_ctrl: operation sequencer
// Steps the datapath through insert, extract, decrease and query.
// ----------------------------------------------------------------------------
module imhpq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_op,
    input  imhpq_pkg::t_dstat i_st,
    input  logic              i_out_busy,
    output logic              o_in_stall,
    output imhpq_pkg::t_dcmd  o_cmd,
    output logic              o_done,
    output logic [1:0]        o_status
);
    import imhpq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_VS, S_DISPATCH, S_UP_RD, S_UP_CHK, S_EX_ROOT, S_EX_TAKE,
        S_EX_PUT, S_DN_L, S_DN_R, S_DN_CHK, S_FINISH
    } t_state;

    t_state      r_state, n_state;
    logic [1:0]  r_op, n_op;
    logic [1:0]  r_status, n_status;
    logic        r_done, n_done;

    assign o_in_stall = (r_state != S_IDLE);
    assign o_done     = r_done;
    assign o_status   = r_status;

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_status = r_status;
        n_done   = 1'b0;
        o_cmd    = DC_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd    = DC_LATCH;
                    n_op     = i_op;
                    n_status = ST_OK;
                    n_state  = S_VS;
                end
            end
            S_VS: begin
                o_cmd   = DC_VS_RD;
                n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (r_op)
                    OP_INSERT: begin
                        if (i_st.vert_bad) begin
                            n_status = ST_ABSENT; n_state = S_FINISH;
                        end else if (i_st.present) begin
                            n_state = S_FINISH;
                        end else if (i_st.full) begin
                            n_status = ST_FULL; n_state = S_FINISH;
                        end else begin
                            o_cmd = DC_INS_START; n_state = S_UP_RD;
                        end
                    end
                    OP_EXTRACT: begin
                        if (i_st.empty) begin
                            n_status = ST_EMPTY; n_state = S_FINISH;
                        end else begin
                            n_state = S_EX_ROOT;
                        end
                    end
                    OP_DECREASE: begin
                        if (!i_st.present) begin
                            n_status = ST_ABSENT; n_state = S_FINISH;
                        end else begin
                            o_cmd = DC_DEC_START; n_state = S_UP_RD;
                        end
                    end
                    default: n_state = S_FINISH;
                endcase
            end
            S_UP_RD: begin
                if (i_st.at_root) begin
                    o_cmd = DC_UP_PLACE; n_state = S_FINISH;
                end else begin
                    o_cmd = DC_UP_RD; n_state = S_UP_CHK;
                end
            end
            S_UP_CHK: begin
                if (i_st.up_go) begin
                    o_cmd = DC_UP_MOVE; n_state = S_UP_RD;
                end else begin
                    o_cmd = DC_UP_PLACE; n_state = S_FINISH;
                end
            end
            S_EX_ROOT: begin
                o_cmd = DC_EX_RD_ROOT; n_state = S_EX_TAKE;
            end
            S_EX_TAKE: begin
                o_cmd = DC_EX_TAKE; n_state = S_EX_PUT;
            end
            S_EX_PUT: begin
                if (i_st.empty) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd = DC_EX_PUT; n_state = S_DN_L;
                end
            end
            S_DN_L: begin
                if (!i_st.dn_has_l) begin
                    o_cmd = DC_DN_PLACE; n_state = S_FINISH;
                end else begin
                    o_cmd = DC_DN_RD_L; n_state = S_DN_R;
                end
            end
            S_DN_R: begin
                // always issued: keeps the left child, reads the right one if any
                o_cmd   = DC_DN_RD_R;
                n_state = S_DN_CHK;
            end
            S_DN_CHK: begin
                if (i_st.dn_go) begin
                    o_cmd = DC_DN_MOVE; n_state = S_DN_L;
                end else begin
                    o_cmd = DC_DN_PLACE; n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!i_out_busy) begin
                    n_done = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_INSERT;
            r_status <= ST_OK;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_status <= n_status;
            r_done   <= n_done;
        end
    end

endmodule

### rtl/core/imhpq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhpq_dp: heap datapath
// Heap entry memory, vertex-to-slot memory with clear sweep, size and cursor.
// ----------------------------------------------------------------------------
module imhpq_dp #(
    parameter int HEAP_CAPACITY = imhpq_pkg::HEAP_CAPACITY_DEF,
    parameter int VERTEX_COUNT  = imhpq_pkg::VERTEX_COUNT_DEF,
    parameter int KEY_BITS      = imhpq_pkg::KEY_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  imhpq_pkg::t_in_item  i_item,
    input  imhpq_pkg::t_dcmd     i_cmd,
    input  logic                 i_done,
    input  logic [1:0]           i_status,
    output imhpq_pkg::t_dstat    o_st,
    output logic                 o_clearing,
    output imhpq_pkg::t_out_item o_res
);
    import imhpq_pkg::*;

    localparam int SW  = $clog2(HEAP_CAPACITY + 1);     // size / slot-map width
    localparam int AW  = $clog2(HEAP_CAPACITY);         // heap address
    localparam int VAW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int VW  = $clog2(VERTEX_COUNT);          // stored vertex width
    localparam int EW  = VW + KEY_BITS;

    logic [EW-1:0] m_heap [HEAP_CAPACITY];
    logic [SW-1:0] m_slot [VERTEX_COUNT];

    logic [1:0]          r_op;
    logic [VERTEX_W-1:0] r_vin;
    logic [KEY_BITS-1:0] r_key;
    logic [SW-1:0]       r_size;
    logic [SW-1:0]       r_cur;
    logic [EW-1:0]       r_hold;      // entry being sifted
    logic [EW-1:0]       r_rd;        // registered heap read
    logic [EW-1:0]       r_lc;        // left child
    logic [SW-1:0]       r_vs;        // registered slot-map read
    logic [VW-1:0]       r_ov;
    logic [KEY_BITS-1:0] r_od;
    logic                r_has_r;
    logic                r_vbad;
    logic [VAW:0]        r_clr;
    logic                r_clearing;
    t_out_item           r_res;

    // heap and slot-map port controls
    logic          hw_en;
    logic [AW-1:0] hw_addr;
    logic [EW-1:0] hw_data;
    logic          hr_en;
    logic [AW-1:0] hr_addr;
    logic          sw_en;
    logic [VAW-1:0] sw_addr;
    logic [SW-1:0] sw_data;
    logic          sr_en;
    logic [VAW-1:0] sr_addr;

    logic [SW-1:0] parent, left, right;
    logic [KEY_BITS-1:0] hold_key, rd_key, lc_key;
    logic [VW-1:0] hold_v, rd_v, lc_v;
    logic          r_wins;

    assign hold_key = r_hold[KEY_BITS-1:0];
    assign hold_v   = r_hold[EW-1:KEY_BITS];
    assign rd_key   = r_rd[KEY_BITS-1:0];
    assign rd_v     = r_rd[EW-1:KEY_BITS];
    assign lc_key   = r_lc[KEY_BITS-1:0];
    assign lc_v     = r_lc[EW-1:KEY_BITS];
    assign parent   = (r_cur - SW'(1)) >> 1;
    assign left     = SW'({r_cur, 1'b1});
    assign right    = left + SW'(1);
    // right child wins only on strictly smaller key than left
    assign r_wins   = r_has_r && (rd_key < lc_key);

    always_comb begin
        o_st.present  = !r_vbad && (r_vs < r_size);
        o_st.full     = (r_size >= SW'(HEAP_CAPACITY));
        o_st.empty    = (r_size == '0);
        o_st.vert_bad = r_vbad;
        o_st.at_root  = (r_cur == '0);
        o_st.up_go    = hold_key < rd_key;
        o_st.dn_has_l = left < r_size;
        o_st.dn_has_r = right < r_size;
        o_st.dn_go    = r_wins ? (rd_key < hold_key) : (lc_key < hold_key);
    end
    assign o_clearing = r_clearing;
    assign o_res      = r_res;

    always_comb begin
        hw_en = 1'b0; hw_addr = r_cur[AW-1:0]; hw_data = r_hold;
        hr_en = 1'b0; hr_addr = parent[AW-1:0];
        sw_en = 1'b0; sw_addr = hold_v[VAW-1:0]; sw_data = r_cur;
        sr_en = 1'b0; sr_addr = r_vin[VAW-1:0];
        if (r_clearing) begin
            sw_en = 1'b1; sw_addr = r_clr[VAW-1:0]; sw_data = '1;
        end
        case (i_cmd)
            DC_VS_RD:      sr_en = 1'b1;
            DC_UP_RD:      hr_en = 1'b1;
            DC_UP_MOVE: begin
                hw_en = 1'b1; hw_data = r_rd;
                sw_en = 1'b1; sw_addr = rd_v[VAW-1:0];
            end
            DC_UP_PLACE, DC_DN_PLACE: begin
                hw_en = 1'b1; sw_en = 1'b1;
            end
            DC_EX_RD_ROOT: begin
                hr_en = 1'b1; hr_addr = '0;
            end
            DC_EX_TAKE: begin
                sw_en = 1'b1; sw_addr = rd_v[VAW-1:0]; sw_data = '1;
                hr_en = 1'b1; hr_addr = AW'(r_size - SW'(1));
            end
            DC_DN_RD_L: begin
                hr_en = 1'b1; hr_addr = left[AW-1:0];
            end
            DC_DN_RD_R: begin
                hr_en = o_st.dn_has_r; hr_addr = right[AW-1:0];
            end
            DC_DN_MOVE: begin
                hw_en = 1'b1;
                hw_data = r_wins ? r_rd : r_lc;
                sw_en = 1'b1;
                sw_addr = r_wins ? rd_v[VAW-1:0] : lc_v[VAW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (hw_en) m_heap[hw_addr] <= hw_data;
        if (hr_en) r_rd <= m_heap[hr_addr];
        if (sw_en) m_slot[sw_addr] <= sw_data;
        if (sr_en) r_vs <= m_slot[sr_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size     <= '0;
            r_clr      <= '0;
            r_clearing <= 1'b1;
            r_res      <= '0;
        end else begin
            if (r_clearing) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == (VAW+1)'(VERTEX_COUNT - 1)) r_clearing <= 1'b0;
            end
            case (i_cmd)
                DC_LATCH: begin
                    r_op   <= i_item.operation;
                    r_vin  <= i_item.vertex;
                    r_key  <= KEY_BITS'(i_item.distance);
                    r_vbad <= (32'(i_item.vertex) >= 32'(VERTEX_COUNT));
                    r_ov   <= '0;
                    r_od   <= '0;
                end
                DC_INS_START: begin
                    r_size <= r_size + SW'(1);
                    r_cur  <= r_size;
                    r_hold <= {VW'(r_vin), r_key};
                end
                DC_DEC_START: begin
                    r_cur  <= r_vs;
                    r_hold <= {VW'(r_vin), r_key};
                end
                DC_UP_MOVE: r_cur <= parent;
                DC_EX_TAKE: begin
                    r_ov   <= rd_v;
                    r_od   <= rd_key;
                    r_size <= r_size - SW'(1);
                end
                DC_EX_PUT: begin
                    r_hold <= r_rd;
                    r_cur  <= '0;
                end
                DC_DN_RD_L: r_has_r <= 1'b0;
                DC_DN_RD_R: begin
                    // left child read has landed; keep it before the right read
                    r_lc    <= r_rd;
                    r_has_r <= o_st.dn_has_r;
                end
                DC_DN_MOVE: r_cur <= r_wins ? right : left;
                default: ;
            endcase
            if (i_done) begin
                r_res.out_vertex   <= (r_op == OP_EXTRACT && i_status == ST_OK) ?
                                      VERTEX_W'(r_ov) : r_vin;
                r_res.out_distance <= (r_op == OP_EXTRACT && i_status == ST_OK) ?
                                      DIST_W'(r_od) : '0;
                r_res.present      <= (r_op == OP_EXTRACT) ? 1'b0 :
                                      (r_op == OP_QUERY) ? o_st.present :
                                      (i_status == ST_OK);
                r_res.heap_empty   <= (r_size == '0);
                r_res.entry_count  <= COUNT_W'(r_size);
                r_res.status       <= i_status;
            end
        end
    end

endmodule

### rtl/core/indexed_min_heap_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_priority_queue_core: indexed binary min-heap
// Dijkstra-style queue of (vertex, distance) with a vertex-to-slot map.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid / o_in_stall / i_in_item) takes one item:
//    insert, extract minimum, decrease key or membership query.
//  - Output channel (o_out_valid / i_out_stall / o_out_item) returns exactly
//    one item per input item, in order, from an output register.
//  - One item at a time. Insert / decrease climb the heap level by level;
//    extract descends it level by level unless it empties the heap. Each
//    level costs a heap memory read, then a compare.
//  - o_in_stall stays high while an item is processed. The next item is
//    taken while a result still waits in the output register; an item that
//    finishes while the previous result is held by a stalled receiver waits.
//  - Reset: heap empty. The vertex slot map is swept to "absent" after
//    reset; o_in_stall is high meanwhile.
// ----------------------------------------------------------------------------
module indexed_min_heap_priority_queue_core #(
    parameter int HEAP_CAPACITY = imhpq_pkg::HEAP_CAPACITY_DEF,
    parameter int VERTEX_COUNT  = imhpq_pkg::VERTEX_COUNT_DEF,
    parameter int KEY_BITS      = imhpq_pkg::KEY_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  imhpq_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output imhpq_pkg::t_out_item o_out_item
);
    import imhpq_pkg::*;

    t_dcmd     cmd;
    t_dstat    st;
    logic      done;
    logic [1:0] status;
    logic      clearing;
    logic      ctrl_stall;
    logic      r_out_valid;
    logic      out_busy;

    // result register still held by a stalled receiver
    assign out_busy    = r_out_valid && i_out_stall;
    assign o_in_stall  = ctrl_stall || clearing;
    assign o_out_valid = r_out_valid;

    imhpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid && !clearing),
        .i_op       (i_in_item.operation),
        .i_st       (st),
        .i_out_busy (out_busy),
        .o_in_stall (ctrl_stall),
        .o_cmd      (cmd),
        .o_done     (done),
        .o_status   (status)
    );

    imhpq_dp #(
        .HEAP_CAPACITY (HEAP_CAPACITY),
        .VERTEX_COUNT  (VERTEX_COUNT),
        .KEY_BITS      (KEY_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_in_item),
        .i_cmd      (cmd),
        .i_done     (done),
        .i_status   (status),
        .o_st       (st),
        .o_clearing (clearing),
        .o_res      (o_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule
